@@ sv/rc4_pkg.sv @@
// Shared types, step codes and the control-store program of the RC4 stream cipher.
// Used by rc4_sequencer, rc4_datapath and the top level; depends on nothing.
package rc4_pkg;

  localparam int unsigned MAX_KEY_BYTES_DEF = 256;
  localparam int unsigned PERM_SIZE         = 256;
  localparam int unsigned IDX_W             = 8;
  localparam int unsigned UPC_W             = 4;

  typedef logic [IDX_W-1:0] byte_t;
  typedef logic [UPC_W-1:0] upc_t;

  // Step addresses of the program
  localparam upc_t STEP_IDLE  = 4'd0;
  localparam upc_t STEP_D2    = 4'd1;
  localparam upc_t STEP_D3    = 4'd2;
  localparam upc_t STEP_D4    = 4'd3;
  localparam upc_t STEP_NOKEY = 4'd4;
  localparam upc_t STEP_KINIT = 4'd5;
  localparam upc_t STEP_FILL  = 4'd6;
  localparam upc_t STEP_S1    = 4'd7;
  localparam upc_t STEP_S2    = 4'd8;
  localparam upc_t STEP_S3    = 4'd9;
  localparam upc_t STEP_S4    = 4'd10;
  localparam upc_t STEP_FIN   = 4'd11;

  // Permutation read address source
  typedef enum logic [2:0] {
    RA_INEXT,  // incremented i of the incoming data item
    RA_JSUM,   // j + S[i]
    RA_TSUM,   // S[i] + S[j]
    RA_N,      // schedule counter
    RA_JKS     // j + S[n] + key byte
  } rd_sel_e;

  // Permutation write address and data source
  typedef enum logic [1:0] {
    WR_I_RD,   // S[i] <= read data
    WR_J_A,    // S[j] <= held entry a
    WR_N_N,    // S[n] <= n (identity fill)
    WR_N_RD    // S[n] <= read data
  } wr_sel_e;

  // Sequencer jump conditions
  typedef enum logic [2:0] {
    JC_NEXT,   // fall through
    JC_ALWAYS, // jump to target
    JC_IDLE,   // dispatch on the incoming item
    JC_EMIT,   // hold while the output slot is busy, then jump
    JC_LOOP    // jump to target until n reaches its last value
  } jcond_e;

  typedef struct packed {
    logic    ready;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    wr_en;
    wr_sel_e wr_sel;
    logic    ld_a;
    logic    ld_j_sum;
    logic    ld_j_ks;
    logic    ld_b;
    logic    ld_t;
    logic    key_rd;
    logic    ks_init;
    logic    n_inc;
    logic    kp_adv;
    logic    emit_data;
    logic    emit_zero;
    logic    key_done;
  } uop_t;

  typedef struct packed {
    uop_t   uop;
    jcond_e cond;
    upc_t   target;
  } ucode_t;

  typedef struct packed {
    logic keyed;
    logic out_busy;
    logic n_last;
  } dp_status_t;

  // Control store: one word per step
  function automatic ucode_t ucode_rom(upc_t upc);
    ucode_t w;
    w = '0;
    w.cond   = JC_NEXT;
    w.target = STEP_IDLE;
    case (upc)
      STEP_IDLE: begin
        w.uop.ready  = 1'b1;
        w.uop.rd_en  = 1'b1;
        w.uop.rd_sel = RA_INEXT;
        w.cond       = JC_IDLE;
        w.target     = STEP_KINIT;
      end
      STEP_D2: begin
        w.uop.rd_en    = 1'b1;
        w.uop.rd_sel   = RA_JSUM;
        w.uop.ld_a     = 1'b1;
        w.uop.ld_j_sum = 1'b1;
      end
      STEP_D3: begin
        w.uop.rd_en  = 1'b1;
        w.uop.rd_sel = RA_TSUM;
        w.uop.wr_en  = 1'b1;
        w.uop.wr_sel = WR_I_RD;
        w.uop.ld_b   = 1'b1;
        w.uop.ld_t   = 1'b1;
      end
      STEP_D4: begin
        w.uop.wr_en     = 1'b1;
        w.uop.wr_sel    = WR_J_A;
        w.uop.emit_data = 1'b1;
        w.cond          = JC_EMIT;
        w.target        = STEP_IDLE;
      end
      STEP_NOKEY: begin
        w.uop.emit_zero = 1'b1;
        w.cond          = JC_EMIT;
        w.target        = STEP_IDLE;
      end
      STEP_KINIT: begin
        w.uop.ks_init = 1'b1;
      end
      STEP_FILL: begin
        w.uop.wr_en  = 1'b1;
        w.uop.wr_sel = WR_N_N;
        w.uop.n_inc  = 1'b1;
        w.cond       = JC_LOOP;
        w.target     = STEP_FILL;
      end
      STEP_S1: begin
        w.uop.rd_en  = 1'b1;
        w.uop.rd_sel = RA_N;
        w.uop.key_rd = 1'b1;
      end
      STEP_S2: begin
        w.uop.rd_en   = 1'b1;
        w.uop.rd_sel  = RA_JKS;
        w.uop.ld_a    = 1'b1;
        w.uop.ld_j_ks = 1'b1;
      end
      STEP_S3: begin
        w.uop.wr_en  = 1'b1;
        w.uop.wr_sel = WR_N_RD;
      end
      STEP_S4: begin
        w.uop.wr_en  = 1'b1;
        w.uop.wr_sel = WR_J_A;
        w.uop.n_inc  = 1'b1;
        w.uop.kp_adv = 1'b1;
        w.cond       = JC_LOOP;
        w.target     = STEP_S1;
      end
      STEP_FIN: begin
        w.uop.key_done = 1'b1;
        w.cond         = JC_ALWAYS;
        w.target       = STEP_IDLE;
      end
      default: begin
        w.cond   = JC_ALWAYS;
        w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

@@ sv/rc4_sequencer.sv @@
// Step counter and jump logic; fetches control words from rc4_pkg::ucode_rom.
// Depends on rc4_pkg.
module rc4_sequencer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_func_i,
  input  logic               in_key_end_i,
  input  rc4_pkg::dp_status_t status_i,
  output rc4_pkg::uop_t      uop_o
);

  rc4_pkg::upc_t   upc_q, upc_d;
  rc4_pkg::ucode_t word;
  rc4_pkg::upc_t   upc_inc;

  assign word    = rc4_pkg::ucode_rom(upc_q);
  assign upc_inc = upc_q + rc4_pkg::upc_t'(1);
  assign uop_o   = word.uop;

  always_comb begin
    case (word.cond)
      rc4_pkg::JC_NEXT:   upc_d = upc_inc;
      rc4_pkg::JC_ALWAYS: upc_d = word.target;
      rc4_pkg::JC_IDLE: begin
        if (!in_valid_i) begin
          upc_d = upc_q;
        end else if (!in_func_i) begin
          upc_d = in_key_end_i ? word.target : upc_q;
        end else begin
          upc_d = status_i.keyed ? upc_inc : rc4_pkg::STEP_NOKEY;
        end
      end
      rc4_pkg::JC_EMIT:   upc_d = status_i.out_busy ? upc_q : word.target;
      rc4_pkg::JC_LOOP:   upc_d = status_i.n_last ? upc_inc : word.target;
      default:            upc_d = rc4_pkg::STEP_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= rc4_pkg::STEP_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

@@ sv/rc4_datapath.sv @@
// Permutation and key memories, index registers and output slot of the cipher.
// Driven by control words from rc4_sequencer; depends on rc4_pkg.
module rc4_datapath #(
  parameter int unsigned MAX_KEY_BYTES = rc4_pkg::MAX_KEY_BYTES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rc4_pkg::uop_t       uop_i,
  input  logic                in_valid_i,
  input  logic                in_func_i,
  input  logic                in_msg_start_i,
  input  logic [7:0]          in_value_i,
  input  logic                out_ready_i,
  output rc4_pkg::dp_status_t status_o,
  output logic                out_valid_o,
  output logic [7:0]          out_byte_o,
  output logic                out_keyed_o
);

  localparam int unsigned CNT_W  = $clog2(MAX_KEY_BYTES + 1);
  localparam int unsigned KIDX_W = $clog2(MAX_KEY_BYTES);

  rc4_pkg::byte_t perm_mem [rc4_pkg::PERM_SIZE];
  logic [7:0]     key_mem  [MAX_KEY_BYTES];

  rc4_pkg::byte_t rd_q, key_rd_q;
  rc4_pkg::byte_t i_q, i_d, j_q, j_d, n_q, n_d;
  rc4_pkg::byte_t a_q, b_q, t_q;
  logic [7:0]     value_q;
  logic [KIDX_W-1:0] kp_q, kp_d;
  logic [CNT_W-1:0]  key_count_q, key_count_d;
  logic keyed_q, keyed_d;
  logic out_valid_q, out_valid_d;
  logic [7:0] out_byte_q;
  logic out_keyed_q;

  logic accept, key_wr, data_acc, out_busy, emit, kp_wrap;
  rc4_pkg::byte_t i_base, i_next, j_sum, j_ks, t_sum, ks_byte;
  rc4_pkg::byte_t rd_addr, wr_addr, wr_data;

  assign accept   = uop_i.ready & in_valid_i;
  assign key_wr   = accept & ~in_func_i & (key_count_q < CNT_W'(MAX_KEY_BYTES));
  assign data_acc = accept & in_func_i & keyed_q;

  assign i_base = in_msg_start_i ? '0 : i_q;
  assign i_next = i_base + rc4_pkg::byte_t'(1);
  assign j_sum  = j_q + rd_q;
  assign j_ks   = j_q + rd_q + key_rd_q;
  assign t_sum  = a_q + rd_q;

  // S[t] was read in the cycle that wrote S[i]; S[j] is written later
  assign ks_byte = (t_q == i_q) ? b_q : ((t_q == j_q) ? a_q : rd_q);

  assign kp_wrap = (CNT_W'(kp_q) + CNT_W'(1)) == key_count_q;

  always_comb begin
    case (uop_i.rd_sel)
      rc4_pkg::RA_INEXT: rd_addr = i_next;
      rc4_pkg::RA_JSUM:  rd_addr = j_sum;
      rc4_pkg::RA_TSUM:  rd_addr = t_sum;
      rc4_pkg::RA_N:     rd_addr = n_q;
      rc4_pkg::RA_JKS:   rd_addr = j_ks;
      default:           rd_addr = n_q;
    endcase
  end

  always_comb begin
    case (uop_i.wr_sel)
      rc4_pkg::WR_I_RD: begin wr_addr = i_q; wr_data = rd_q; end
      rc4_pkg::WR_J_A:  begin wr_addr = j_q; wr_data = a_q;  end
      rc4_pkg::WR_N_N:  begin wr_addr = n_q; wr_data = n_q;  end
      rc4_pkg::WR_N_RD: begin wr_addr = n_q; wr_data = rd_q; end
      default:          begin wr_addr = n_q; wr_data = rd_q; end
    endcase
  end

  // Permutation memory: one write, one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (uop_i.wr_en) begin
      perm_mem[wr_addr] <= wr_data;
    end
    if (uop_i.rd_en) begin
      rd_q <= perm_mem[rd_addr];
    end
  end

  // Key memory
  always_ff @(posedge clk_i) begin
    if (key_wr) begin
      key_mem[key_count_q[KIDX_W-1:0]] <= in_value_i;
    end
    if (uop_i.key_rd) begin
      key_rd_q <= key_mem[kp_q];
    end
  end

  always_comb begin
    i_d = i_q;
    j_d = j_q;
    if (uop_i.key_done) begin
      i_d = '0;
      j_d = '0;
    end else begin
      if (data_acc) begin
        i_d = i_next;
        j_d = in_msg_start_i ? '0 : j_q;
      end
      if (uop_i.ld_j_sum) j_d = j_sum;
      if (uop_i.ld_j_ks)  j_d = j_ks;
      if (uop_i.ks_init)  j_d = '0;
    end
  end

  always_comb begin
    n_d  = n_q;
    kp_d = kp_q;
    if (uop_i.ks_init) begin
      n_d  = '0;
      kp_d = '0;
    end else begin
      if (uop_i.n_inc)  n_d = n_q + rc4_pkg::byte_t'(1);
      if (uop_i.kp_adv) kp_d = kp_wrap ? '0 : kp_q + KIDX_W'(1);
    end
  end

  always_comb begin
    key_count_d = key_count_q;
    keyed_d     = keyed_q;
    if (uop_i.key_done) begin
      key_count_d = '0;
      keyed_d     = 1'b1;
    end else if (key_wr) begin
      key_count_d = key_count_q + CNT_W'(1);
    end
  end

  assign out_busy    = out_valid_q & ~out_ready_i;
  assign emit        = (uop_i.emit_data | uop_i.emit_zero) & ~out_busy;
  assign out_valid_d = emit | (out_valid_q & ~out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q         <= '0;
      j_q         <= '0;
      key_count_q <= '0;
      keyed_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      i_q         <= i_d;
      j_q         <= j_d;
      key_count_q <= key_count_d;
      keyed_q     <= keyed_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q  <= n_d;
    kp_q <= kp_d;
    if (accept)       value_q <= in_value_i;
    if (uop_i.ld_a)   a_q <= rd_q;
    if (uop_i.ld_b)   b_q <= rd_q;
    if (uop_i.ld_t)   t_q <= t_sum;
    if (emit) begin
      out_byte_q  <= uop_i.emit_data ? (value_q ^ ks_byte) : 8'h00;
      out_keyed_q <= uop_i.emit_data;
    end
  end

  assign status_o.keyed    = keyed_q;
  assign status_o.out_busy = out_busy;
  assign status_o.n_last   = (n_q == rc4_pkg::byte_t'(rc4_pkg::PERM_SIZE - 1));

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_keyed_o = out_keyed_q;

endmodule

@@ sv/rc4_stream_cipher.sv @@
// Top level of the RC4 stream cipher: stream ports around sequencer and datapath.
// Depends on rc4_pkg, rc4_sequencer and rc4_datapath.
//
// RC4 byte cipher on stream ports. Send key bytes with tuser[0] = 0; the first
// MAX_KEY_BYTES of a key are stored and the rest dropped. The key byte with
// tlast high starts the key schedule, which holds tready low from that item
// on until it ends (one init step, 256 identity writes, 4 steps per scrambling
// swap and one closing step). The permutation memory does one read and one
// write per cycle, and that sets these steps. A data byte (tuser[0] = 1) runs
// through the idle step and steps D2 to D4: one read of S[i], one of S[j],
// one of S[t] with the S[i] write, then the S[j] write and the result load.
// A data byte sent before any key runs through the idle step and the step
// that loads its zero result. A result that cannot load because the previous
// one still waits holds the sequencer in its last step. A non-final key byte
// is taken in the idle step, where the sequencer stays. Set tuser[1] on a
// data byte to restart i and j at zero for a new message; the permutation
// carries over. Data sent before any key gives a result of zero with keyed
// low. Each data item yields exactly one result item; key items yield none.
// The result register lets the next item be taken while a result waits.
module rc4_stream_cipher #(
  parameter int unsigned MAX_KEY_BYTES = rc4_pkg::MAX_KEY_BYTES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] value
  input  logic [1:0] s_axis_tuser_i,   // [0] func, [1] message_start
  input  logic       s_axis_tlast_i,   // key_end
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_byte
  output logic       m_axis_tuser_o    // [0] keyed
);

  rc4_pkg::uop_t       uop;
  rc4_pkg::dp_status_t status;

  // Step through the control program
  rc4_sequencer u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_func_i    (s_axis_tuser_i[0]),
    .in_key_end_i (s_axis_tlast_i),
    .status_i     (status),
    .uop_o        (uop)
  );

  // Memories, indices and the result slot
  rc4_datapath #(
    .MAX_KEY_BYTES (MAX_KEY_BYTES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .uop_i          (uop),
    .in_valid_i     (s_axis_tvalid_i),
    .in_func_i      (s_axis_tuser_i[0]),
    .in_msg_start_i (s_axis_tuser_i[1]),
    .in_value_i     (s_axis_tdata_i),
    .out_ready_i    (m_axis_tready_i),
    .status_o       (status),
    .out_valid_o    (m_axis_tvalid_o),
    .out_byte_o     (m_axis_tdata_o),
    .out_keyed_o    (m_axis_tuser_o)
  );

  // Take an item only in the idle step
  assign s_axis_tready_o = uop.ready;

endmodule

@@ sv/rc4_checker.sv @@
// Port-level checks of rc4_stream_cipher, attached by the bind at the end.
// Depends only on the top level's ports.
module rc4_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid_i,
  input logic       s_axis_tready_o,
  input logic [1:0] s_axis_tuser_i,
  input logic       s_axis_tlast_i,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o,
  input logic       m_axis_tuser_o
);

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("stalled result changed");

  // A data item occupies the sequencer for the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tuser_i[0] |=> !s_axis_tready_o)
    else $error("ready after data item");

  // The last key byte starts the schedule
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && !s_axis_tuser_i[0] && s_axis_tlast_i
      |=> !s_axis_tready_o ##1 !s_axis_tready_o)
    else $error("ready during key schedule");

  // An unkeyed result carries zero data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |-> m_axis_tdata_o == 8'h00)
    else $error("unkeyed result not zero");

endmodule

bind rc4_stream_cipher rc4_checker u_checker (.*);
